// ===== design/cslfa_pkg.sv =====
`default_nettype none

package cslfa_pkg;

    localparam int unsigned DEF_CAPACITY = 65536;
    localparam int unsigned ID_SPACE     = 65536;

    localparam int ID_W      = 16;
    localparam int CNT_W     = 17;
    localparam int CFG_W     = 17;
    localparam int STATUS_W  = 2;
    localparam int REG_IDX_W = 1;

    localparam logic [CFG_W-1:0] RST_START_CHUNK = 17'd4048;
    localparam logic [CFG_W-1:0] RST_GROW_CHUNK  = 17'd1024;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_START_CHUNK = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_GROW_CHUNK  = 1'b1;

    // two-entry queues on both sides of the back part
    localparam logic [1:0] Q_FULL = 2'd2;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t       kind;
        logic [ID_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]     slot;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    pool;
    } result_t;

    typedef enum logic {
        BK_FETCH  = 1'b0,
        BK_COMMIT = 1'b1
    } bk_state_t;

    function automatic int unsigned eff_cap(input int unsigned cap);
        return (cap < ID_SPACE) ? cap : ID_SPACE;
    endfunction

endpackage

`default_nettype wire

// ===== design/chunked_slot_free_list_allocator_unit.sv =====
// channel   direction  handshake          payload
// request   in         push / full        op, slot_in
// result    out        empty / pop        slot_out, status, pool_size
// config    in         cfg_we             cfg_index, cfg_data
//
// in the execution stage each request is a read of the free-list stack and
// the in-use bitmap, then decision and write-back into both memories, and only then
// is another taken. a push goes through request queue, latched request and result queue.
// no clearing pass after reset: bitmap entries at or above the fresh-ID mark read as free.
// a 2-beat request queue and a 2-beat result queue let each side stall on its own.
`default_nettype none

module chunked_slot_free_list_allocator_unit #(
    parameter int unsigned CAPACITY = cslfa_pkg::DEF_CAPACITY
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            op,
    input  wire logic [cslfa_pkg::ID_W-1:0]      slot_in,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [cslfa_pkg::ID_W-1:0]           slot_out,
    output logic [cslfa_pkg::STATUS_W-1:0]       status,
    output logic [cslfa_pkg::CNT_W-1:0]          pool_size,
    input  wire logic                            cfg_we,
    input  wire logic [cslfa_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [cslfa_pkg::CFG_W-1:0]     cfg_data
);
    import cslfa_pkg::*;

    localparam int unsigned EFF_CAP = eff_cap(CAPACITY);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    cslfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .slot_in   (slot_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    cslfa_back #(
        .EFF_CAP (EFF_CAP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .slot_out  (slot_out),
        .status    (status),
        .pool_size (pool_size)
    );

endmodule

`default_nettype wire

// ===== design/cslfa_front.sv =====
`default_nettype none

module cslfa_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       op,
    input  wire logic [cslfa_pkg::ID_W-1:0] slot_in,
    output logic                            cmd_valid,
    output cslfa_pkg::cmd_t                 cmd,
    input  wire logic                       cmd_take
);
    import cslfa_pkg::*;

    cmd_t       q_reg [2];
    cmd_t       cmd_in;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       put, take;

    // classify the request
    always_comb
    begin
        cmd_in.kind = op ? REQ_FREE : REQ_ALLOC;
        cmd_in.slot = slot_in;
    end

    assign full      = (count_reg == Q_FULL);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign put       = push && !full;
    assign take      = cmd_valid && cmd_take;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ put;
        rd_ptr_next = rd_ptr_reg ^ take;
        count_next  = count_reg + {1'b0, put} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("front queue count out of range");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (put && !take) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("front queue lost a beat on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !put) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("front queue lost a beat on take");
`endif

endmodule

`default_nettype wire

// ===== design/cslfa_back.sv =====
`default_nettype none

module cslfa_back #(
    parameter int unsigned EFF_CAP = cslfa_pkg::DEF_CAPACITY
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    input  wire cslfa_pkg::cmd_t                 cmd,
    output logic                                 cmd_take,
    input  wire logic                            cfg_we,
    input  wire logic [cslfa_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [cslfa_pkg::CFG_W-1:0]     cfg_data,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [cslfa_pkg::ID_W-1:0]           slot_out,
    output logic [cslfa_pkg::STATUS_W-1:0]       status,
    output logic [cslfa_pkg::CNT_W-1:0]          pool_size
);
    import cslfa_pkg::*;

    localparam int AW = $clog2(EFF_CAP);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(EFF_CAP);

    // memories
    logic [AW-1:0] stack_mem [EFF_CAP];
    logic          map_mem   [EFF_CAP];

    bk_state_t        state_reg, state_next;
    logic             commit;

    logic [CFG_W-1:0] start_chunk_reg, grow_chunk_reg;
    logic [CNT_W-1:0] freed_count_reg, freed_count_next;
    logic [CNT_W-1:0] next_fresh_reg, next_fresh_next;
    logic [CNT_W-1:0] pool_count_reg, pool_count_next;

    cmd_t             cur_reg;
    logic [AW-1:0]    stack_rd_reg;
    logic             map_rd_reg;
    logic [CNT_W-1:0] grown_pool_reg;

    logic [CNT_W-1:0] fc_minus;
    logic [CFG_W-1:0] chunk_sel, chunk;
    logic [CNT_W-1:0] room, grown_pool;
    logic             in_use;

    logic             stack_we;
    logic [AW-1:0]    stack_waddr, stack_wdata;
    logic             map_we, map_wdata;
    logic [AW-1:0]    map_waddr;
    result_t          res;

    result_t          oq_reg [2];
    logic             oq_wr_reg, oq_rd_reg;
    logic [1:0]       oq_count_reg;
    logic             oq_pop;

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_FETCH:
            begin
                if (cmd_valid && (oq_count_reg != Q_FULL))
                begin
                    state_next = BK_COMMIT;
                end
            end
            BK_COMMIT: state_next = BK_FETCH;
            default:   state_next = BK_FETCH;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        cmd_take = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            BK_FETCH:  cmd_take = cmd_valid && (oq_count_reg != Q_FULL);
            BK_COMMIT: commit = 1'b1;
            default:   cmd_take = 1'b0;
        endcase
    end

    // growth size, worked out while the memories are read
    always_comb
    begin
        fc_minus   = freed_count_reg - CNT_W'(1);
        chunk_sel  = (pool_count_reg == '0) ? start_chunk_reg : grow_chunk_reg;
        chunk      = (chunk_sel == '0) ? CFG_W'(1) : chunk_sel;
        room       = CAP_C - pool_count_reg;
        grown_pool = pool_count_reg + ((chunk > room) ? room : chunk);
    end

    // bitmap entries at or above the fresh mark were never set
    assign in_use = map_rd_reg && (CNT_W'(cur_reg.slot) < next_fresh_reg);

    always_comb
    begin
        freed_count_next = freed_count_reg;
        next_fresh_next  = next_fresh_reg;
        pool_count_next  = pool_count_reg;
        stack_we         = 1'b0;
        stack_waddr      = freed_count_reg[AW-1:0];
        stack_wdata      = cur_reg.slot[AW-1:0];
        map_we           = 1'b0;
        map_waddr        = cur_reg.slot[AW-1:0];
        map_wdata        = 1'b0;
        res.slot         = '0;
        res.status       = ST_OK;
        if (commit)
        begin
            if (cur_reg.kind == REQ_ALLOC)
            begin
                if (freed_count_reg != '0)
                begin
                    freed_count_next = fc_minus;
                    res.slot         = ID_W'(stack_rd_reg);
                    map_we           = 1'b1;
                    map_waddr        = stack_rd_reg;
                    map_wdata        = 1'b1;
                end
                else if ((next_fresh_reg < pool_count_reg) || (pool_count_reg < CAP_C))
                begin
                    if (next_fresh_reg >= pool_count_reg)
                    begin
                        pool_count_next = grown_pool_reg;
                    end
                    res.slot        = next_fresh_reg[ID_W-1:0];
                    next_fresh_next = next_fresh_reg + CNT_W'(1);
                    map_we          = 1'b1;
                    map_waddr       = next_fresh_reg[AW-1:0];
                    map_wdata       = 1'b1;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            else
            begin
                res.slot = cur_reg.slot;
                if (CNT_W'(cur_reg.slot) >= pool_count_reg)
                begin
                    res.status = ST_RANGE;
                end
                else if (!in_use)
                begin
                    res.status = ST_NOT_USED;
                end
                else
                begin
                    map_we = 1'b1;
                    if (freed_count_reg < CAP_C)
                    begin
                        stack_we         = 1'b1;
                        freed_count_next = freed_count_reg + CNT_W'(1);
                    end
                end
            end
        end
        res.pool = pool_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_FETCH;
            start_chunk_reg <= RST_START_CHUNK;
            grow_chunk_reg  <= RST_GROW_CHUNK;
            freed_count_reg <= '0;
            next_fresh_reg  <= '0;
            pool_count_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            freed_count_reg <= freed_count_next;
            next_fresh_reg  <= next_fresh_next;
            pool_count_reg  <= pool_count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_CHUNK: start_chunk_reg <= cfg_data;
                    REG_GROW_CHUNK:  grow_chunk_reg  <= cfg_data;
                    default:         start_chunk_reg <= start_chunk_reg;
                endcase
            end
        end
    end

    // read side of the memories and the latched request
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg        <= cmd;
            grown_pool_reg <= grown_pool;
            stack_rd_reg   <= stack_mem[fc_minus[AW-1:0]];
            map_rd_reg     <= map_mem[cmd.slot[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
    end

    // result queue
    assign empty     = (oq_count_reg == 2'd0);
    assign oq_pop    = pop && !empty;
    assign slot_out  = oq_reg[oq_rd_reg].slot;
    assign status    = oq_reg[oq_rd_reg].status;
    assign pool_size = oq_reg[oq_rd_reg].pool;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= 2'd0;
        end
        else
        begin
            oq_wr_reg    <= oq_wr_reg ^ commit;
            oq_rd_reg    <= oq_rd_reg ^ oq_pop;
            oq_count_reg <= oq_count_reg + {1'b0, commit} - {1'b0, oq_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            oq_reg[oq_wr_reg] <= res;
        end
    end

`ifndef SYNTHESIS
    a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (oq_count_reg != Q_FULL))
        else $error("result queue overrun on commit");

    a_fresh_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        next_fresh_reg <= pool_count_reg)
        else $error("fresh mark beyond pool size");

    a_pool_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pool_count_reg <= CAP_C)
        else $error("pool size beyond capacity");

    a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        freed_count_reg <= next_fresh_reg)
        else $error("more freed slots than ever handed out");

    a_take_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> (state_reg == BK_COMMIT))
        else $error("taken request not committed");
`endif

endmodule

`default_nettype wire
